>>> sv/tvts_pkg.sv
// Shared types and constants for the two-voice tune sequencer.
// Holds the item and result structs, command codes and the queue entry type.
// No dependencies.
package tvts_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 9;
	localparam int WORD_W      = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam logic [PADDR_W-1:0] REG_TUNE_LEN = 3'h0;

	localparam logic [2:0] CMD_LOAD    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_BEAT    = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_STOP    = 3'd4;
	localparam logic [2:0] CMD_PLAY    = 3'd5;
	localparam logic [2:0] CMD_SILENCE = 3'd6;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_START,
		OP_BEAT,
		OP_TICK,
		OP_STOP,
		OP_PLAY,
		OP_SILENCE,
		OP_NOP
	} op_e_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic              voice;
		logic [7:0]        entry_index;
		logic [WORD_W-1:0] word_value;
	} item_t;

	typedef struct packed {
		logic main_level;
		logic aux_level;
		logic main_running;
		logic aux_running;
		logic tune_playing;
	} result_t;

	typedef struct packed {
		op_e_t             op;
		logic              voice;
		logic              wr_ok;
		logic [7:0]        entry;
		logic [WORD_W-1:0] word;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  head;
	} queue_head_t;

endpackage

>>> sv/tvts_front.sv
// Front end: accepts items, classifies each command and queues it.
// Depends on tvts_pkg.
module tvts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  tvts_pkg::item_t      item,
	output tvts_pkg::queue_head_t qhead,
	input  logic                 pop
);

	tvts_pkg::op_t                   queue_q [tvts_pkg::QUEUE_DEPTH];
	logic [tvts_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tvts_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tvts_pkg::QCNT_W-1:0]     count_q;
	tvts_pkg::op_t                   cls;
	logic                            push;
	logic                            do_pop;

	always_comb begin
		cls.voice = item.voice;
		cls.entry = item.entry_index;
		cls.word  = item.word_value;
		cls.wr_ok = (32'(item.entry_index) < tvts_pkg::TABLE_DEPTH);
		case (item.cmd)
			tvts_pkg::CMD_LOAD:    cls.op = tvts_pkg::OP_LOAD;
			tvts_pkg::CMD_START:   cls.op = tvts_pkg::OP_START;
			tvts_pkg::CMD_BEAT:    cls.op = tvts_pkg::OP_BEAT;
			tvts_pkg::CMD_TICK:    cls.op = tvts_pkg::OP_TICK;
			tvts_pkg::CMD_STOP:    cls.op = tvts_pkg::OP_STOP;
			tvts_pkg::CMD_PLAY:    cls.op = tvts_pkg::OP_PLAY;
			tvts_pkg::CMD_SILENCE: cls.op = tvts_pkg::OP_SILENCE;
			default:               cls.op = tvts_pkg::OP_NOP;
		endcase
	end

	assign item_stall  = (count_q == tvts_pkg::QCNT_W'(tvts_pkg::QUEUE_DEPTH));
	assign push        = item_valid && !item_stall;
	assign do_pop      = pop && (count_q != '0);
	assign qhead.valid = (count_q != '0);
	assign qhead.head  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/tvts_back.sv
// Back end: executes queued commands against the tune tables and tone voices.
// Holds both tune memories, the playback and tone state and the result register.
// Depends on tvts_pkg.
module tvts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tvts_pkg::queue_head_t         qhead,
	output logic                          pop,
	input  logic [tvts_pkg::IDX_W-1:0]    tune_len,
	output logic                          result_valid,
	input  logic                          result_stall,
	output tvts_pkg::result_t             result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_NOTE,
		S_DUR,
		S_RESP
	} state_t;

	localparam int AW = tvts_pkg::ADDR_W;
	localparam int IW = tvts_pkg::IDX_W;
	localparam int WW = tvts_pkg::WORD_W;

	state_t          state_q;
	logic [WW-1:0]   mem_a [tvts_pkg::TABLE_DEPTH];
	logic [WW-1:0]   mem_b [tvts_pkg::TABLE_DEPTH];
	logic [WW-1:0]   rd_a_q;
	logic [WW-1:0]   rd_b_q;
	logic            rng_a_q;
	logic            rng_b_q;

	logic [WW-1:0]   beat_q;
	logic [IW-1:0]   idx_a_q;
	logic [IW-1:0]   idx_b_q;
	logic [WW-1:0]   note_a_q;
	logic [WW-1:0]   note_b_q;
	logic [WW-1:0]   due_a_q;
	logic [WW-1:0]   due_b_q;
	logic            playing_q;
	logic [WW-1:0]   reload_m_q;
	logic [WW-1:0]   reload_x_q;
	logic [WW-1:0]   count_m_q;
	logic [WW-1:0]   count_x_q;
	logic            run_m_q;
	logic            run_x_q;
	logic            lvl_m_q;
	logic            lvl_x_q;
	logic            adv_a_q;
	logic            adv_b_q;
	logic            start_q;
	logic            res_valid_q;
	tvts_pkg::result_t res_q;

	tvts_pkg::op_t   op;
	logic            is_start;
	logic            due_a;
	logic            due_b;
	logic [IW-1:0]   rd_idx_a;
	logic [IW-1:0]   rd_idx_b;
	logic [AW-1:0]   addr_a;
	logic [AW-1:0]   addr_b;
	logic            we_a;
	logic            we_b;
	logic            out_free;

	assign op       = qhead.head;
	assign is_start = (op.op == tvts_pkg::OP_START);
	assign due_a    = ($signed(beat_q) >= $signed(due_a_q));
	assign due_b    = ($signed(beat_q) >= $signed(due_b_q));
	assign pop      = (state_q == S_IDLE) && qhead.valid;
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		if (state_q == S_IDLE && is_start) begin
			rd_idx_a = '0;
			rd_idx_b = '0;
		end else begin
			rd_idx_a = idx_a_q + 1'b1;
			rd_idx_b = idx_b_q + 1'b1;
		end
		we_a = pop && (op.op == tvts_pkg::OP_LOAD) && op.wr_ok && !op.voice;
		we_b = pop && (op.op == tvts_pkg::OP_LOAD) && op.wr_ok && op.voice;
		addr_a = we_a ? AW'(op.entry) : AW'(rd_idx_a);
		addr_b = we_b ? AW'(op.entry) : AW'(rd_idx_b);
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[addr_a] <= op.word;
		end
		rd_a_q  <= mem_a[addr_a];
		rng_a_q <= (32'(rd_idx_a) < tvts_pkg::TABLE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[addr_b] <= op.word;
		end
		rd_b_q  <= mem_b[addr_b];
		rng_b_q <= (32'(rd_idx_b) < tvts_pkg::TABLE_DEPTH);
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			beat_q      <= '0;
			idx_a_q     <= '0;
			idx_b_q     <= '0;
			note_a_q    <= '0;
			note_b_q    <= '0;
			due_a_q     <= '0;
			due_b_q     <= '0;
			playing_q   <= 1'b0;
			reload_m_q  <= '0;
			reload_x_q  <= '0;
			count_m_q   <= '0;
			count_x_q   <= '0;
			run_m_q     <= 1'b0;
			run_x_q     <= 1'b0;
			lvl_m_q     <= 1'b0;
			lvl_x_q     <= 1'b0;
			adv_a_q     <= 1'b0;
			adv_b_q     <= 1'b0;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (qhead.valid) begin
						state_q <= (is_start || (op.op == tvts_pkg::OP_BEAT && playing_q))
							? S_NOTE : S_RESP;
						case (op.op)
							tvts_pkg::OP_START: begin
								beat_q  <= '0;
								idx_a_q <= '0;
								idx_b_q <= '0;
								adv_a_q <= 1'b1;
								adv_b_q <= 1'b1;
								start_q <= 1'b1;
							end
							tvts_pkg::OP_BEAT: begin
								if (playing_q) begin
									adv_a_q <= due_a;
									adv_b_q <= due_b;
									start_q <= 1'b0;
									if (due_a) begin
										idx_a_q <= rd_idx_a;
										if (note_a_q == '0) begin
											run_m_q <= 1'b0;
										end else begin
											reload_m_q <= note_a_q;
											count_m_q  <= note_a_q;
											run_m_q    <= 1'b1;
										end
									end
									if (due_b) begin
										idx_b_q <= rd_idx_b;
										if (note_b_q == '0) begin
											run_x_q <= 1'b0;
										end else begin
											reload_x_q <= note_b_q;
											count_x_q  <= note_b_q;
											run_x_q    <= 1'b1;
										end
									end
								end
							end
							tvts_pkg::OP_TICK: begin
								if (run_m_q) begin
									if (count_m_q == '1) begin
										lvl_m_q   <= !lvl_m_q;
										count_m_q <= reload_m_q;
									end else begin
										count_m_q <= count_m_q + 1'b1;
									end
								end
								if (run_x_q) begin
									if (count_x_q == '1) begin
										lvl_x_q   <= !lvl_x_q;
										count_x_q <= reload_x_q;
									end else begin
										count_x_q <= count_x_q + 1'b1;
									end
								end
							end
							tvts_pkg::OP_STOP: begin
								run_m_q   <= 1'b0;
								run_x_q   <= 1'b0;
								playing_q <= 1'b0;
							end
							tvts_pkg::OP_PLAY: begin
								if (op.voice) begin
									reload_x_q <= op.word;
									count_x_q  <= op.word;
									run_x_q    <= 1'b1;
								end else begin
									reload_m_q <= op.word;
									count_m_q  <= op.word;
									run_m_q    <= 1'b1;
								end
							end
							tvts_pkg::OP_SILENCE: begin
								run_m_q <= 1'b0;
								run_x_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_NOTE: begin
					if (adv_a_q) begin
						note_a_q <= rng_a_q ? rd_a_q : '0;
						idx_a_q  <= rd_idx_a;
					end
					if (adv_b_q) begin
						note_b_q <= rng_b_q ? rd_b_q : '0;
						idx_b_q  <= rd_idx_b;
					end
					state_q <= S_DUR;
				end
				S_DUR: begin
					if (adv_a_q) begin
						due_a_q <= (rng_a_q ? rd_a_q : '0) + beat_q;
					end
					if (adv_b_q) begin
						due_b_q <= (rng_b_q ? rd_b_q : '0) + beat_q;
					end
					if (!start_q) begin
						beat_q <= beat_q + 1'b1;
					end
					if (idx_a_q >= tune_len) begin
						run_m_q   <= 1'b0;
						run_x_q   <= 1'b0;
						playing_q <= 1'b0;
					end else begin
						playing_q <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						res_q.main_level   <= lvl_m_q;
						res_q.aux_level    <= lvl_x_q;
						res_q.main_running <= run_m_q;
						res_q.aux_running  <= run_x_q;
						res_q.tune_playing <= playing_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/two_voice_tune_sequencer.sv
// Two-voice tune sequencer with square-wave tone voices: top level.
// Holds the register port and connects tvts_front and tvts_back; uses tvts_pkg.
//
// Every item gives exactly one result beat with both voice levels, both run flags and the
// playback flag after the command. Load, timer tick, stop, play, silence, an idle beat tick
// and unused codes go from idle to the result state in the back end; start tune and a beat
// tick during playback pass the note and duration states first, for the two dependent reads of
// each single-port tune memory (note, then duration). A two-entry queue in front of the back end
// and a result register behind it let items arrive and results leave while the back end works.
// Tune tables must be loaded before they are read; the register tune_length_words sits at byte address 0.
module two_voice_tune_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tvts_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output tvts_pkg::result_t              result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tvts_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [tvts_pkg::IDX_W-1:0] tune_len_q;
	tvts_pkg::queue_head_t      qhead;
	logic                       pop;

	assign pready = 1'b1;
	assign prdata = (paddr == tvts_pkg::REG_TUNE_LEN) ? 32'(tune_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_len_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr == tvts_pkg::REG_TUNE_LEN) begin
			tune_len_q <= pwdata[tvts_pkg::IDX_W-1:0];
		end
	end

	tvts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.qhead      (qhead),
		.pop        (pop)
	);

	tvts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qhead        (qhead),
		.pop          (pop),
		.tune_len     (tune_len_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> bench/two_voice_tune_sequencer_tb.sv
// Self-checking bench for the two-voice tune sequencer: loads tune tables, plays tunes and
// tones under random idling and stalls, and checks every result beat against a local model.
// Depends on tvts_pkg and two_voice_tune_sequencer.
`timescale 1ns / 1ps

module two_voice_tune_sequencer_tb;

	class tune_scoreboard;
		logic [15:0] tab [2][256];
		bit          written [2][256];
		logic [8:0]  idx [2];
		logic [15:0] note [2];
		logic [15:0] due [2];
		logic [15:0] reload [2];
		logic [15:0] count [2];
		bit          run [2];
		bit          level [2];
		logic [15:0] beat;
		bit          playing;
		logic [8:0]  tune_len;
		tvts_pkg::result_t expected_levels [$];
		int          errors;
		int          beats_seen;

		function new();
			for (int k = 0; k < 2; k++) begin
				idx[k] = '0;
				note[k] = '0;
				due[k] = '0;
				reload[k] = '0;
				count[k] = '0;
				run[k] = 0;
				level[k] = 0;
			end
			beat = '0;
			playing = 0;
			tune_len = '0;
			errors = 0;
			beats_seen = 0;
		endfunction

		task report(input string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		function int pending();
			return expected_levels.size();
		endfunction

		function logic [15:0] word_at(input int v, input logic [8:0] i);
			return i[8] ? 16'h0000 : tab[v][i[7:0]];
		endfunction

		function void start_tone(input int v, input logic [15:0] n);
			reload[v] = n;
			count[v] = n;
			run[v] = 1;
		endfunction

		function void advance(input int v);
			if (note[v] == 16'h0000)
				run[v] = 0;
			else
				start_tone(v, note[v]);
			idx[v] = idx[v] + 9'd1;
			note[v] = word_at(v, idx[v]);
			idx[v] = idx[v] + 9'd1;
			due[v] = word_at(v, idx[v]) + beat;
		endfunction

		function void tone_tick(input int v);
			if (run[v]) begin
				if (count[v] == 16'hFFFF) begin
					level[v] = !level[v];
					count[v] = reload[v];
				end else begin
					count[v] = count[v] + 16'd1;
				end
			end
		endfunction

		function void end_check();
			if (idx[0] >= tune_len) begin
				run[0] = 0;
				run[1] = 0;
				playing = 0;
			end
		endfunction

		// Report the first table word that the item would read before it was ever loaded.
		function bit unread_entry(input tvts_pkg::item_t it, output int v, output logic [7:0] e);
			logic [8:0] i;
			int k;
			int j;
			v = 0;
			e = '0;
			if (it.cmd == tvts_pkg::OP_START) begin
				for (k = 0; k < 2; k++)
					for (j = 0; j < 2; j++)
						if (!written[k][j]) begin
							v = k;
							e = j[7:0];
							return 1;
						end
			end else if (it.cmd == tvts_pkg::OP_BEAT && playing) begin
				for (k = 0; k < 2; k++)
					if ($signed(beat) >= $signed(due[k]))
						for (j = 1; j <= 2; j++) begin
							i = idx[k] + 9'(j);
							if (!i[8] && !written[k][i[7:0]]) begin
								v = k;
								e = i[7:0];
								return 1;
							end
						end
			end
			return 0;
		endfunction

		function void note_item(input tvts_pkg::item_t it);
			tvts_pkg::result_t r;
			case (tvts_pkg::op_e_t'(it.cmd))
				tvts_pkg::OP_LOAD: begin
					tab[it.voice][it.entry_index] = it.word_value;
					written[it.voice][it.entry_index] = 1;
				end
				tvts_pkg::OP_START: begin
					beat = '0;
					for (int k = 0; k < 2; k++) begin
						note[k] = word_at(k, 9'd0);
						idx[k] = 9'd1;
						due[k] = word_at(k, 9'd1);
					end
					playing = 1;
					end_check();
				end
				tvts_pkg::OP_BEAT: begin
					if (playing) begin
						if ($signed(beat) >= $signed(due[0]))
							advance(0);
						if ($signed(beat) >= $signed(due[1]))
							advance(1);
						beat = beat + 16'd1;
						end_check();
					end
				end
				tvts_pkg::OP_TICK: begin
					tone_tick(0);
					tone_tick(1);
				end
				tvts_pkg::OP_STOP: begin
					run[0] = 0;
					run[1] = 0;
					playing = 0;
				end
				tvts_pkg::OP_PLAY: start_tone(it.voice, it.word_value);
				tvts_pkg::OP_SILENCE: begin
					run[0] = 0;
					run[1] = 0;
				end
				default: ;
			endcase
			r.main_level = level[0];
			r.aux_level = level[1];
			r.main_running = run[0];
			r.aux_running = run[1];
			r.tune_playing = playing;
			expected_levels.push_back(r);
		endfunction

		task compare_bit(input string name, input logic got, input logic want);
			if (got !== want)
				report($sformatf("result %0d: %s is %b, want %b", beats_seen, name, got, want));
		endtask

		task check_result(input tvts_pkg::result_t r);
			tvts_pkg::result_t want;
			if (expected_levels.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", beats_seen));
			end else begin
				want = expected_levels.pop_front();
				compare_bit("main_level", r.main_level, want.main_level);
				compare_bit("aux_level", r.aux_level, want.aux_level);
				compare_bit("main_running", r.main_running, want.main_running);
				compare_bit("aux_running", r.aux_running, want.aux_running);
				compare_bit("tune_playing", r.tune_playing, want.tune_playing);
			end
			beats_seen++;
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_stall;
	tvts_pkg::item_t              item;
	logic                         result_valid;
	logic                         result_stall;
	tvts_pkg::result_t            result;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [tvts_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	tune_scoreboard board = new();
	bit             send_busy;
	bit             recv_busy;

	two_voice_tune_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function int pick_gap(input bit busy);
		return busy ? $urandom_range(0, 13) : 0;
	endfunction

	function tvts_pkg::item_t make_item(input tvts_pkg::op_e_t op, input logic v,
			input logic [7:0] e, input logic [15:0] w);
		tvts_pkg::item_t it;
		it.cmd = op;
		it.voice = v;
		it.entry_index = e;
		it.word_value = w;
		return it;
	endfunction

	function logic [15:0] note_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'($urandom);
			2, 3: return 16'hFFFF - 16'($urandom_range(0, 5));
			4: return 16'hFFF0 | 16'($urandom_range(0, 15));
			default: return 16'($urandom_range(1, 255));
		endcase
	endfunction

	function logic [15:0] duration_word();
		case ($urandom_range(0, 9))
			0: return 16'h8000 | 16'($urandom);
			1: return 16'($urandom_range(4, 40));
			2: return 16'hFFFF;
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	function logic [15:0] tune_word(input logic odd);
		return odd ? duration_word() : note_word();
	endfunction

	function tvts_pkg::item_t random_item(input bit beat_heavy);
		tvts_pkg::item_t it;
		int r;
		it = make_item(tvts_pkg::OP_NOP, 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), 16'($urandom));
		r = $urandom_range(0, 99);
		if (beat_heavy)
			it.cmd = (r < 94) ? tvts_pkg::OP_BEAT : tvts_pkg::OP_TICK;
		else if (r < 38)
			it.cmd = tvts_pkg::OP_BEAT;
		else if (r < 68)
			it.cmd = tvts_pkg::OP_TICK;
		else if (r < 76) begin
			it.cmd = tvts_pkg::OP_LOAD;
			it.word_value = tune_word(it.entry_index[0]);
		end else if (r < 80)
			it.cmd = tvts_pkg::OP_START;
		else if (r < 83)
			it.cmd = tvts_pkg::OP_STOP;
		else if (r < 90) begin
			it.cmd = tvts_pkg::OP_PLAY;
			it.word_value = note_word();
		end else if (r < 93)
			it.cmd = tvts_pkg::OP_SILENCE;
		else if (r < 96)
			it.cmd = tvts_pkg::OP_NOP;
		else
			it.cmd = tvts_pkg::OP_PLAY;
		return it;
	endfunction

	// Enter and leave at a falling edge; valid stays high after the beat is taken.
	task send_beat(input tvts_pkg::item_t it);
		int gap;
		gap = pick_gap(send_busy);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		board.note_item(it);
		@(negedge clk);
	endtask

	// Load any table word the item would read that was never loaded, before sending it.
	task issue(input tvts_pkg::item_t it);
		int v;
		logic [7:0] e;
		while (board.unread_entry(it, v, e))
			send_beat(make_item(tvts_pkg::OP_LOAD, v[0], e, tune_word(e[0])));
		send_beat(it);
	endtask

	task wait_results_drained();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task set_tune_length(input logic [8:0] len);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tvts_pkg::REG_TUNE_LEN;
		pwdata <= {23'b0, len};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.tune_len = len;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== len)
			board.report($sformatf("tune_length_words reads %0d, wrote %0d", prdata[8:0], len));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		repeat (6) @(negedge clk);
	endtask

	task run_phase(input logic [8:0] len, input int n, input bit beat_heavy);
		int i;
		set_tune_length(len);
		send_busy = $urandom_range(0, 2) != 0;
		recv_busy = $urandom_range(0, 2) != 0;
		issue(make_item(tvts_pkg::OP_START, 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), 16'($urandom)));
		for (i = 0; i < n; i++) begin
			issue(random_item(beat_heavy));
			if (i == n / 2 && $urandom_range(0, 1) == 1)
				wait_results_drained();
		end
	endtask

	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int gap;
			gap = pick_gap(recv_busy);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			board.check_result(result);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_busy = 0;
		recv_busy = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_tune_length(9'd0);
		issue(make_item(tvts_pkg::OP_TICK, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_NOP, 1'b1, 8'hFF, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_PLAY, 1'b0, 8'h00, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_PLAY, 1'b1, 8'hFF, 16'h0000));
		issue(make_item(tvts_pkg::OP_TICK, 1'b1, 8'hFF, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_TICK, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_SILENCE, 1'b1, 8'hFF, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b0, 8'h00, 16'hFFFE));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b0, 8'h01, 16'h0000));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b1, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b1, 8'h01, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b0, 8'hFF, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b1, 8'hFF, 16'h0000));
		issue(make_item(tvts_pkg::OP_START, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_STOP, 1'b0, 8'h00, 16'h0000));

		set_tune_length(9'd4);
		issue(make_item(tvts_pkg::OP_LOAD, 1'b0, 8'h02, 16'hFFFD));
		issue(make_item(tvts_pkg::OP_LOAD, 1'b0, 8'h03, 16'h0001));
		issue(make_item(tvts_pkg::OP_START, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_TICK, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_TICK, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_START, 1'b1, 8'hFF, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_PLAY, 1'b1, 8'h00, 16'hFFFF));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_BEAT, 1'b0, 8'h00, 16'h0000));
		issue(make_item(tvts_pkg::OP_STOP, 1'b1, 8'hFF, 16'hFFFF));

		run_phase(9'd1, 60, 0);
		run_phase(9'd256, 450, 1);
		run_phase(9'd2, 60, 0);
		run_phase(9'd255, 80, 1);
		repeat (5)
			run_phase(9'($urandom_range(3, 40)), 70, $urandom_range(0, 3) == 0);
		run_phase(9'd0, 30, 0);

		wait_results_drained();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
